FILE: rtl/core/pcr_pkg.sv
// Shared types and codes for the polar cap rearrange block.
// No dependencies; imported by pcr_xform, polar_cap_rearrange and the testbench.
`timescale 1ns / 1ps

package pcr_pkg;

  // Width of every coordinate word on the ports.
  localparam int unsigned CoordW = 32;

  // Direction of the move.
  typedef enum logic {
    FUNC_COMBINE = 1'b0,
    FUNC_SPLIT   = 1'b1
  } func_e;

  // Region of the sphere a point belongs to.
  typedef enum logic [1:0] {
    REG_EQUAT = 2'd0,
    REG_NORTH = 2'd1,
    REG_SOUTH = 2'd2
  } region_e;

  // Configuration register indexes.
  typedef enum logic {
    CFG_NORTH_SLOT = 1'b0,
    CFG_SOUTH_SLOT = 1'b1
  } cfg_idx_e;

  // One input word.
  typedef struct packed {
    func_e                    func;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
  } item_t;

  // One result word.
  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    region_e                  region;
    logic [1:0]               cap;
  } res_t;

endpackage

FILE: rtl/core/pcr_xform.sv
// Combinational classify, rotate and translate step for one point.
// Depends on pcr_pkg; instantiated by polar_cap_rearrange.
`timescale 1ns / 1ps

module pcr_xform #(
  parameter int unsigned FRAC_BITS = 28
) (
  input  pcr_pkg::item_t item_i,
  input  logic [1:0]     north_slot_i,
  input  logic [1:0]     south_slot_i,
  output pcr_pkg::res_t  res_o
);
  import pcr_pkg::*;

  // Internal words hold the input range plus several units of offset.
  localparam int unsigned MagBits = (FRAC_BITS > CoordW - 1) ? FRAC_BITS : CoordW - 1;
  localparam int unsigned W       = MagBits + 6;

  localparam logic signed [W-1:0] Unit  = {{(W-1){1'b0}}, 1'b1} << FRAC_BITS;
  localparam logic signed [W-1:0] Unit2 = Unit <<< 1;
  localparam logic signed [W-1:0] Unit3 = Unit2 + Unit;
  localparam logic signed [W-1:0] Unit4 = Unit <<< 2;
  localparam logic signed [W-1:0] Unit5 = Unit4 + Unit;
  localparam logic signed [W-1:0] Unit6 = Unit4 + Unit2;
  localparam logic signed [W-1:0] SatMax = {{(W-CoordW+1){1'b0}}, {(CoordW-1){1'b1}}};
  localparam logic signed [W-1:0] SatMin = ~SatMax;

  // Pole point x of cap or slot n: (2n - 3) units.
  function automatic logic signed [W-1:0] pole_x(input logic [1:0] n);
    logic signed [W-1:0] v;
    unique case (n)
      2'd0:    v = -Unit3;
      2'd1:    v = -Unit;
      2'd2:    v = Unit;
      default: v = Unit3;
    endcase
    return v;
  endfunction

  // Offset of slot n inside the polar square row: 2n units.
  function automatic logic signed [W-1:0] slot_off(input logic [1:0] n);
    logic signed [W-1:0] v;
    unique case (n)
      2'd0:    v = '0;
      2'd1:    v = Unit2;
      2'd2:    v = Unit4;
      default: v = Unit6;
    endcase
    return v;
  endfunction

  // Clamp an internal word to the signed port range.
  function automatic logic signed [CoordW-1:0] sat(input logic signed [W-1:0] v);
    logic signed [CoordW-1:0] r;
    if (v > SatMax) begin
      r = SatMax[CoordW-1:0];
    end else if (v < SatMin) begin
      r = SatMin[CoordW-1:0];
    end else begin
      r = v[CoordW-1:0];
    end
    return r;
  endfunction

  logic signed [W-1:0] x, y, cx, cy, ax, xs, d1, d2, dx, dy, rx, ry;
  logic                north, south;
  logic [1:0]          pole, cn, k;

  always_comb begin
    x = W'(item_i.x);
    y = W'(item_i.y);

    // Region classification by latitude band.
    north = (y > Unit);
    south = (y < -Unit);
    pole  = north ? north_slot_i : south_slot_i;
    cy    = north ? Unit2 : -Unit2;

    xs = x - slot_off(pole);
    d1 = '0;
    d2 = '0;
    cn = pole;
    k  = '0;

    // Cap selection and rotation count.
    if (item_i.func == FUNC_COMBINE) begin
      priority if (x < -Unit2) begin
        cn = 2'd0;
      end else if (x < 0) begin
        cn = 2'd1;
      end else if (x < Unit2) begin
        cn = 2'd2;
      end else begin
        cn = 2'd3;
      end
      cx = pole_x(cn);
      ax = pole_x(pole);
      k  = north ? (cn - pole) : (pole - cn);
    end else begin
      cx = pole_x(pole);
      if (north) begin
        // Diagonals of the north square split it into four triangles.
        d1 = -xs - Unit;
        d2 = xs + Unit5;
        priority if (y >= d1 && y < d2) begin
          cn = pole + 2'd1;
        end else if (y > d1 && y >= d2) begin
          cn = pole + 2'd2;
        end else if (y <= d1 && y > d2) begin
          cn = pole + 2'd3;
        end else begin
          cn = pole;
        end
        k = pole - cn;
      end else begin
        d1 = xs + Unit;
        d2 = -xs - Unit5;
        priority if (y <= d1 && y > d2) begin
          cn = pole + 2'd1;
        end else if (y < d1 && y <= d2) begin
          cn = pole + 2'd2;
        end else if (y >= d1 && y < d2) begin
          cn = pole + 2'd3;
        end else begin
          cn = pole;
        end
        k = cn - pole;
      end
      ax = pole_x(cn);
    end

    // Quarter-turn rotation about the pole point.
    dx = x - cx;
    dy = y - cy;
    unique case (k)
      2'd0:    begin rx = dx;  ry = dy;  end
      2'd1:    begin rx = -dy; ry = dx;  end
      2'd2:    begin rx = -dx; ry = -dy; end
      default: begin rx = dy;  ry = -dx; end
    endcase

    // Equatorial points pass through untouched.
    if (north || south) begin
      res_o.x      = sat(rx + ax);
      res_o.y      = sat(ry + cy);
      res_o.region = north ? REG_NORTH : REG_SOUTH;
      res_o.cap    = cn;
    end else begin
      res_o.x      = item_i.x;
      res_o.y      = item_i.y;
      res_o.region = REG_EQUAT;
      res_o.cap    = 2'd0;
    end
  end

endmodule

FILE: rtl/core/polar_cap_rearrange.sv
// Top level of the polar cap rearrange block: input register, transform, result register.
// Depends on pcr_pkg and pcr_xform.
//
// Usage: points arrive on the input channel (in_valid_i, in_stall_o, func_i, x_in_i,
// y_in_i) and leave on the output channel (out_valid_o, out_stall_i, x_out_o, y_out_o,
// region_o, cap_number_o). A word moves at a clock edge where valid is high and stall
// is low. Each input word gives exactly one result word, in order.
// The result word shows on out_valid_o once its input word has passed both registers:
// the accepting edge loads the input register, and a later edge loads the result
// register through the transform logic when the result register is not stalled.
// Throughput is one point per cycle while out_stall_i is low; the two registers act
// as a two-entry pipeline. When the receiver stalls, the result register holds its word
// and the input register can still take one more point; after that in_stall_o is raised.
// The slot registers are written through cfg_we_i, cfg_idx_i and cfg_data_i and
// should only change while no point is in flight.
// Reset empties both registers and clears both slots to zero.
`timescale 1ns / 1ps

module polar_cap_rearrange #(
  parameter int unsigned FRAC_BITS = 28
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration write port
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [1:0]                   cfg_data_i,
  // Input channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         func_i,
  input  logic signed [31:0]           x_in_i,
  input  logic signed [31:0]           y_in_i,
  // Output channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [31:0]           x_out_o,
  output logic signed [31:0]           y_out_o,
  output logic [1:0]                   region_o,
  output logic [1:0]                   cap_number_o
);
  import pcr_pkg::*;

  logic [1:0] north_slot_q, south_slot_q;
  logic       s1_valid_q, s2_valid_q;
  item_t      s1_item_q;
  res_t       s2_res_q, s2_res_d;
  logic       s1_stall, s2_load, s1_load;

  // Slot registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      north_slot_q <= '0;
      south_slot_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_NORTH_SLOT: north_slot_q <= cfg_data_i;
        CFG_SOUTH_SLOT: south_slot_q <= cfg_data_i;
      endcase
    end
  end

  // Pipeline flow control: a stage moves on when the one after it is empty or draining.
  assign s1_stall   = s2_valid_q && out_stall_i;
  assign s2_load    = s1_valid_q && !s1_stall;
  assign in_stall_o = s1_valid_q && s1_stall;
  assign s1_load    = in_valid_i && !in_stall_o;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_item_q.func <= func_e'(func_i);
      s1_item_q.x    <= x_in_i;
      s1_item_q.y    <= y_in_i;
    end
  end

  // Transform logic between the two registers.
  pcr_xform #(
    .FRAC_BITS(FRAC_BITS)
  ) u_xform (
    .item_i      (s1_item_q),
    .north_slot_i(north_slot_q),
    .south_slot_i(south_slot_q),
    .res_o       (s2_res_d)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (!s1_stall) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      s2_res_q <= s2_res_d;
    end
  end

  assign out_valid_o  = s2_valid_q;
  assign x_out_o      = s2_res_q.x;
  assign y_out_o      = s2_res_q.y;
  assign region_o     = s2_res_q.region;
  assign cap_number_o = s2_res_q.cap;

`ifndef NO_ASSERTIONS
  // An accepted word always lands in the input register.
  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_load |=> s1_valid_q)
    else $error("accepted word did not reach the input register");

  // Upstream is only held back when the input register is occupied.
  a_stall_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> !in_stall_o)
    else $error("input stalled with an empty input register");

  // A held input word keeps its contents until it moves on.
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_stall) |=> $stable(s1_item_q))
    else $error("held input word changed");

  // Equatorial results always report cap zero.
  a_equat_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && region_o == REG_EQUAT) |-> cap_number_o == 2'd0)
    else $error("equatorial result with nonzero cap");
`endif

endmodule

FILE: tb/sv/polar_cap_rearrange_tb.sv
// Self-checking testbench for polar_cap_rearrange: directed and random points in both
// directions under several slot settings, checked against a built-in predictor.
// Depends on pcr_pkg and the polar_cap_rearrange RTL.
`timescale 1ns / 1ps

module polar_cap_rearrange_tb;
  import pcr_pkg::*;

  localparam int unsigned FracBits = 28;
  localparam longint Unit = longint'(1) << FracBits;
  localparam int PhasePoints = 280;
  localparam int StallLimit = 4000;
  localparam int HoldCycles = 64;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic cfg_we = 1'b0;
  cfg_idx_e cfg_idx = CFG_NORTH_SLOT;
  logic [1:0] cfg_data = 2'd0;

  logic in_valid = 1'b0;
  logic in_stall;
  func_e func = FUNC_COMBINE;
  logic signed [31:0] x_in = '0;
  logic signed [31:0] y_in = '0;

  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] x_out;
  logic signed [31:0] y_out;
  logic [1:0] region;
  logic [1:0] cap_number;

  // Slot settings as the block should hold them.
  logic [1:0] north_slot = 2'd0;
  logic [1:0] south_slot = 2'd0;

  item_t points_todo[$];
  res_t moves_due[$];
  int errors = 0;
  int sent_cnt = 0;
  int got_cnt = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int quiet_cycles = 0;

  polar_cap_rearrange #(
    .FRAC_BITS(FracBits)
  ) DUT (
    .clk_i(clk),
    .rst_ni(rst_n),
    .cfg_we_i(cfg_we),
    .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data),
    .in_valid_i(in_valid),
    .in_stall_o(in_stall),
    .func_i(func),
    .x_in_i(x_in),
    .y_in_i(y_in),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .x_out_o(x_out),
    .y_out_o(y_out),
    .region_o(region),
    .cap_number_o(cap_number)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Clamp a wide value to the signed 32-bit range.
  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return 32'(v);
  endfunction

  // Work out the moved point, its region and its cap for one input word.
  function automatic res_t predict_move(item_t p, logic [1:0] ns, logic [1:0] ss);
    longint x, y, cx, cy, ax, dx, dy, rx, ry, xs, d1, d2;
    int pole, cn, k;
    res_t r;
    x = p.x;
    y = p.y;
    if (y > Unit) begin
      r.region = REG_NORTH;
      cy = 2 * Unit;
      pole = ns;
    end else if (y < -Unit) begin
      r.region = REG_SOUTH;
      cy = -2 * Unit;
      pole = ss;
    end else begin
      r.x = p.x;
      r.y = p.y;
      r.region = REG_EQUAT;
      r.cap = 2'd0;
      return r;
    end

    if (p.func == FUNC_COMBINE) begin
      // Cap from the x band, then rotate it onto the configured slot.
      if (x < -2 * Unit) cn = 0;
      else if (x < 0) cn = 1;
      else if (x < 2 * Unit) cn = 2;
      else cn = 3;
      cx = (2 * cn - 3) * Unit;
      ax = (2 * pole - 3) * Unit;
      k = (r.region == REG_NORTH) ? (cn - pole) : (pole - cn);
    end else begin
      // The square's diagonals decide which cap a point came from.
      xs = x - 2 * pole * Unit;
      cx = (2 * pole - 3) * Unit;
      if (r.region == REG_NORTH) begin
        d1 = -xs - Unit;
        d2 = xs + 5 * Unit;
        if (y >= d1 && y < d2) cn = (pole + 1) & 3;
        else if (y > d1 && y >= d2) cn = (pole + 2) & 3;
        else if (y <= d1 && y > d2) cn = (pole + 3) & 3;
        else cn = pole;
        k = pole - cn;
      end else begin
        d1 = xs + Unit;
        d2 = -xs - 5 * Unit;
        if (y <= d1 && y > d2) cn = (pole + 1) & 3;
        else if (y < d1 && y <= d2) cn = (pole + 2) & 3;
        else if (y >= d1 && y < d2) cn = (pole + 3) & 3;
        else cn = pole;
        k = cn - pole;
      end
      ax = (2 * cn - 3) * Unit;
    end

    // Anticlockwise quarter turns about the pole point.
    dx = x - cx;
    dy = y - cy;
    case (k & 3)
      0: begin rx = dx;  ry = dy;  end
      1: begin rx = -dy; ry = dx;  end
      2: begin rx = -dx; ry = -dy; end
      default: begin rx = dy; ry = -dx; end
    endcase
    r.x = clamp32(rx + ax);
    r.y = clamp32(ry + cy);
    r.cap = 2'(cn & 3);
    return r;
  endfunction

  task automatic add_point(func_e f, longint x, longint y);
    item_t p;
    p.func = f;
    p.x = 32'(x);
    p.y = 32'(y);
    points_todo.push_back(p);
  endtask

  // Wait until every word has gone through and nothing is left in the pipeline.
  task automatic wait_drained();
    do @(negedge clk);
    while (points_todo.size() > 0 || in_valid || moves_due.size() > 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_slot(cfg_idx_e idx, logic [1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_NORTH_SLOT) north_slot = val;
    else south_slot = val;
  endtask

  // Input driver: offers queued points, holds a stalled word, idles at random.
  always @(posedge clk or negedge rst_n) begin
    item_t nxt;
    bit calm;
    if (!rst_n) begin
      in_valid <= 1'b0;
      func <= FUNC_COMBINE;
      x_in <= '0;
      y_in <= '0;
    end else begin
      calm = (sent_cnt >= 500 && sent_cnt < 800);
      if (in_valid && !in_stall) begin
        nxt.func = func;
        nxt.x = x_in;
        nxt.y = y_in;
        moves_due.push_back(predict_move(nxt, north_slot, south_slot));
        sent_cnt++;
      end
      if (!in_valid || !in_stall) begin
        if (points_todo.size() > 0 && (calm || $urandom_range(0, 99) >= 16)) begin
          nxt = points_todo.pop_front();
          in_valid <= 1'b1;
          func <= nxt.func;
          x_in <= nxt.x;
          y_in <= nxt.y;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each word against the oldest prediction and drives stall.
  always @(posedge clk or negedge rst_n) begin
    res_t want;
    bit calm;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      calm = (got_cnt >= 500 && got_cnt < 800);
      if (out_valid && !out_stall) begin
        got_cnt++;
        if (moves_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("Unexpected word: x %0d y %0d region %0d cap %0d",
                     x_out, y_out, region, cap_number);
        end else begin
          want = moves_due.pop_front();
          if (x_out !== want.x || y_out !== want.y || region !== want.region ||
              cap_number !== want.cap) begin
            errors++;
            if (errors <= 10)
              $display("Mismatch on word %0d: want x %0d y %0d region %0d cap %0d,",
                       got_cnt, want.x, want.y, want.region, want.cap,
                       " got x %0d y %0d region %0d cap %0d",
                       x_out, y_out, region, cap_number);
          end
        end
      end
      // One long hold-off lets the pipeline fill and push back on the input.
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && got_cnt >= 300) begin
        hold_done = 1'b1;
        hold_left = HoldCycles - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < 16);
      end
    end
  end

  // Watchdog on cycles in which no word moves on either side.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Stimulus: directed points under reset slots, then random phases per setting.
  initial begin
    logic [1:0] north_list [5];
    logic [1:0] south_list [5];
    func_e f;
    int kind, sgn, pole;
    longint px, py, xs, off;

    north_list = '{2'd3, 2'd1, 2'd2, 2'd0, 2'd3};
    south_list = '{2'd3, 2'd2, 2'd0, 2'd3, 2'd1};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Range extremes, band edges in both axes and points on the square diagonals.
    add_point(FUNC_COMBINE, 0, 0);
    add_point(FUNC_COMBINE, -64'sd2147483648, -64'sd2147483648);
    add_point(FUNC_COMBINE, 64'sd2147483647, 64'sd2147483647);
    add_point(FUNC_SPLIT, -64'sd2147483648, 64'sd2147483647);
    add_point(FUNC_SPLIT, 64'sd2147483647, -64'sd2147483648);
    add_point(FUNC_COMBINE, Unit, Unit);
    add_point(FUNC_COMBINE, Unit, Unit + 1);
    add_point(FUNC_COMBINE, -Unit, -Unit);
    add_point(FUNC_COMBINE, -Unit, -Unit - 1);
    add_point(FUNC_COMBINE, -2 * Unit - 1, 2 * Unit);
    add_point(FUNC_COMBINE, -2 * Unit, 2 * Unit);
    add_point(FUNC_COMBINE, -1, 2 * Unit);
    add_point(FUNC_COMBINE, 0, -2 * Unit);
    add_point(FUNC_COMBINE, 2 * Unit - 1, -2 * Unit);
    add_point(FUNC_COMBINE, 2 * Unit, -2 * Unit);
    add_point(FUNC_SPLIT, -3 * Unit, 2 * Unit);
    add_point(FUNC_SPLIT, -2 * Unit, 3 * Unit);
    add_point(FUNC_SPLIT, -4 * Unit, 3 * Unit);
    add_point(FUNC_SPLIT, -3 * Unit + 5, 2 * Unit - 3);
    add_point(FUNC_SPLIT, -3 * Unit, -2 * Unit);
    add_point(FUNC_SPLIT, -2 * Unit, -3 * Unit);
    add_point(FUNC_SPLIT, -4 * Unit, -Unit - 1);
    add_point(FUNC_SPLIT, -3 * Unit - 7, -2 * Unit + 2);
    add_point(FUNC_SPLIT, 5 * Unit, 2 * Unit);
    wait_drained();

    for (int ph = 0; ph < 5; ph++) begin
      write_slot(CFG_NORTH_SLOT, north_list[ph]);
      write_slot(CFG_SOUTH_SLOT, south_list[ph]);
      for (int n = 0; n < PhasePoints; n++) begin
        f = func_e'($urandom_range(0, 1));
        kind = $urandom_range(0, 9);
        sgn = $urandom_range(0, 1) ? 1 : -1;
        case (kind)
          0, 1: begin
            px = $signed($urandom);
            py = $signed($urandom);
          end
          2, 3, 4, 5: begin
            // Polar point somewhere over the caps and squares.
            px = -4 * Unit + longint'($urandom_range(0, 32'h7FFF_FFFF));
            py = sgn * (Unit + 1 + longint'($urandom_range(0, 32'h1FFF_FFFF)));
          end
          6: begin
            // Close to a band edge in x and y.
            px = longint'($urandom_range(0, 4)) * 2 * Unit - 4 * Unit
                 + longint'($urandom_range(0, 2)) - 1;
            py = sgn * (Unit + longint'($urandom_range(0, 2)) - 1
                 + ($urandom_range(0, 1) ? Unit : 0));
          end
          7, 8: begin
            // On or next to a diagonal of the configured square.
            if (kind == 7) f = FUNC_SPLIT;
            pole = (sgn > 0) ? north_slot : south_slot;
            xs = -4 * Unit + longint'($urandom_range(0, 32'h1FFF_FFFF));
            off = longint'($urandom_range(0, 2)) - 1;
            if (sgn > 0) py = ($urandom_range(0, 1) ? -xs - Unit : xs + 5 * Unit) + off;
            else py = ($urandom_range(0, 1) ? xs + Unit : -xs - 5 * Unit) + off;
            px = xs + 2 * pole * Unit;
          end
          default: begin
            // Near the range limits, where results saturate.
            px = $urandom_range(0, 1) ? 64'sd2147483647 - $urandom_range(0, 255)
                                      : -64'sd2147483648 + $urandom_range(0, 255);
            py = sgn > 0 ? 64'sd2147483647 - $urandom_range(0, 255)
                         : -64'sd2147483648 + $urandom_range(0, 255);
          end
        endcase
        add_point(f, px, py);
      end
      wait_drained();
    end

    if (errors == 0 && moves_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
